/* rtl/core/rfpa_pkg.sv */
// rfpa_pkg: shared types and constants of the replay filtered packet admission block
// holds item and configuration structs, opcode and verdict codes, fsm state encoding
// no dependencies
package rfpa_pkg;

    // port widths
    localparam int ADDR_W    = 6;
    localparam int APB_W     = 64;
    localparam int S_TDATA_W = 168;
    localparam int S_TUSER_W = 8;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 3;

    // register indexes (paddr[5:3])
    localparam logic [2:0] REG_LOCAL_MAC      = 3'd0;
    localparam logic [2:0] REG_PROTO_VERSION  = 3'd1;
    localparam logic [2:0] REG_REPLAY_WINDOW  = 3'd2;
    localparam logic [2:0] REG_WEIGHT_MAX     = 3'd3;
    localparam logic [2:0] REG_ACCUM_LIMIT    = 3'd4;
    localparam logic [2:0] REG_POSTURE_THRESH = 3'd5;
    localparam logic [2:0] REG_QUERY_INTERVAL = 3'd6;

    // register reset values
    localparam logic [47:0] RST_LOCAL_MAC      = 48'd0;
    localparam logic [7:0]  RST_PROTO_VERSION  = 8'h02;
    localparam logic [31:0] RST_REPLAY_WINDOW  = 32'd2000000;
    localparam logic [3:0]  RST_WEIGHT_MAX     = 4'd4;
    localparam logic [14:0] RST_ACCUM_LIMIT    = 15'd20;
    localparam logic [14:0] RST_POSTURE_THRESH = 15'd10;
    localparam logic [31:0] RST_QUERY_INTERVAL = 32'd100000;

    // opcodes
    localparam logic [7:0] OPC_SYNC      = 8'h00;
    localparam logic [7:0] OPC_QUERY     = 8'hDE;
    localparam logic [7:0] OPC_ADVERTISE = 8'hAD;
    localparam logic [7:0] OPC_POSTURE   = 8'hCC;
    localparam logic [7:0] OPC_REGSYNC   = 8'h10;

    localparam logic [3:0] WEIGHT_NIBBLE = 4'hF;

    // operation classes
    localparam logic [2:0] CLS_SYNC      = 3'd0;
    localparam logic [2:0] CLS_QUERY     = 3'd1;
    localparam logic [2:0] CLS_ADVERTISE = 3'd2;
    localparam logic [2:0] CLS_POSTURE   = 3'd3;
    localparam logic [2:0] CLS_REGSYNC   = 3'd4;
    localparam logic [2:0] CLS_OTHER     = 3'd5;

    // verdicts
    localparam logic [2:0] VERDICT_OK      = 3'd0;
    localparam logic [2:0] VERDICT_BAD_LEN = 3'd1;
    localparam logic [2:0] VERDICT_SELF    = 3'd2;
    localparam logic [2:0] VERDICT_VERSION = 3'd3;
    localparam logic [2:0] VERDICT_CHECK   = 3'd4;
    localparam logic [2:0] VERDICT_REPLAY  = 3'd5;

    // posture levels
    localparam logic signed [1:0] LEVEL_LOW  = -2'sd1;
    localparam logic signed [1:0] LEVEL_MID  = 2'sd0;
    localparam logic signed [1:0] LEVEL_HIGH = 2'sd1;

    typedef struct packed {
        logic [47:0] local_mac;
        logic [7:0]  protocol_version;
        logic [31:0] replay_window_us;
        logic [3:0]  weight_max;
        logic [14:0] accum_limit;
        logic [14:0] posture_threshold;
        logic [31:0] query_interval_us;
    } cfg_t;

    typedef struct packed {
        logic [47:0]        src_mac;
        logic               length_ok;
        logic [7:0]         version;
        logic [7:0]         opcode;
        logic signed [7:0]  cell_state;
        logic [31:0]        nonce;
        logic               check_ok;
        logic [63:0]        now_us;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         verdict;
        logic [2:0]         op_class;
        logic               query_due;
        logic               posture_update;
        logic signed [1:0]  posture_level;
        logic signed [15:0] accum_value;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic load;   // capture accepted input transaction
        logic quot;   // quotient estimate and prechecks
        logic rem;    // remainder of slot hash
        logic rd;     // slot memory read
        logic eval;   // verdict, write back, output load
        logic clr;    // one step of the clearing pass
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
    } dp_status_t;

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_QUOT  = 6'b000100,
        ST_REM   = 6'b001000,
        ST_READ  = 6'b010000,
        ST_EVAL  = 6'b100000
    } state_t;

    function automatic logic [2:0] classify(input logic [7:0] op);
        logic [2:0] cls;
        case (op)
            OPC_SYNC:      cls = CLS_SYNC;
            OPC_QUERY:     cls = CLS_QUERY;
            OPC_ADVERTISE: cls = CLS_ADVERTISE;
            OPC_POSTURE:   cls = CLS_POSTURE;
            OPC_REGSYNC:   cls = CLS_REGSYNC;
            default:       cls = CLS_OTHER;
        endcase
        return cls;
    endfunction

endpackage

/* rtl/core/rfpa_cfg.sv */
// rfpa_cfg: apb register file for the admission block configuration
// depends on rfpa_pkg (cfg_t, register indexes and reset values)
module rfpa_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rfpa_pkg::ADDR_W-1:0] paddr,
    input  logic [rfpa_pkg::APB_W-1:0]  pwdata,
    output logic [rfpa_pkg::APB_W-1:0]  prdata,
    output logic                        pready,
    output rfpa_pkg::cfg_t              cfg
);

    rfpa_pkg::cfg_t cfg_reg;
    rfpa_pkg::cfg_t cfg_next;
    logic           wr_en;
    logic [2:0]     reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[5:3];
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                rfpa_pkg::REG_LOCAL_MAC:      cfg_next.local_mac         = pwdata[47:0];
                rfpa_pkg::REG_PROTO_VERSION:  cfg_next.protocol_version  = pwdata[7:0];
                rfpa_pkg::REG_REPLAY_WINDOW:  cfg_next.replay_window_us  = pwdata[31:0];
                rfpa_pkg::REG_WEIGHT_MAX:     cfg_next.weight_max        = pwdata[3:0];
                rfpa_pkg::REG_ACCUM_LIMIT:    cfg_next.accum_limit       = pwdata[14:0];
                rfpa_pkg::REG_POSTURE_THRESH: cfg_next.posture_threshold = pwdata[14:0];
                rfpa_pkg::REG_QUERY_INTERVAL: cfg_next.query_interval_us = pwdata[31:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.local_mac         <= rfpa_pkg::RST_LOCAL_MAC;
            cfg_reg.protocol_version  <= rfpa_pkg::RST_PROTO_VERSION;
            cfg_reg.replay_window_us  <= rfpa_pkg::RST_REPLAY_WINDOW;
            cfg_reg.weight_max        <= rfpa_pkg::RST_WEIGHT_MAX;
            cfg_reg.accum_limit       <= rfpa_pkg::RST_ACCUM_LIMIT;
            cfg_reg.posture_threshold <= rfpa_pkg::RST_POSTURE_THRESH;
            cfg_reg.query_interval_us <= rfpa_pkg::RST_QUERY_INTERVAL;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (reg_idx)
            rfpa_pkg::REG_LOCAL_MAC:      prdata = {16'd0, cfg_reg.local_mac};
            rfpa_pkg::REG_PROTO_VERSION:  prdata = {56'd0, cfg_reg.protocol_version};
            rfpa_pkg::REG_REPLAY_WINDOW:  prdata = {32'd0, cfg_reg.replay_window_us};
            rfpa_pkg::REG_WEIGHT_MAX:     prdata = {60'd0, cfg_reg.weight_max};
            rfpa_pkg::REG_ACCUM_LIMIT:    prdata = {49'd0, cfg_reg.accum_limit};
            rfpa_pkg::REG_POSTURE_THRESH: prdata = {49'd0, cfg_reg.posture_threshold};
            rfpa_pkg::REG_QUERY_INTERVAL: prdata = {32'd0, cfg_reg.query_interval_us};
            default:                      prdata = '0;
        endcase
    end

endmodule

/* rtl/core/rfpa_ctrl.sv */
// rfpa_ctrl: sequencing state machine and output valid of the admission block
// depends on rfpa_pkg (state_t, dp_cmd_t, dp_status_t)
module rfpa_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output rfpa_pkg::dp_cmd_t    cmd,
    input  rfpa_pkg::dp_status_t status
);

    rfpa_pkg::state_t state_reg;
    rfpa_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == rfpa_pkg::ST_IDLE);
    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            rfpa_pkg::ST_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (status.clr_last)
                begin
                    state_next = rfpa_pkg::ST_IDLE;
                end
            end
            rfpa_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = rfpa_pkg::ST_QUOT;
                end
            end
            rfpa_pkg::ST_QUOT:
            begin
                cmd.quot   = 1'b1;
                state_next = rfpa_pkg::ST_REM;
            end
            rfpa_pkg::ST_REM:
            begin
                cmd.rem    = 1'b1;
                state_next = rfpa_pkg::ST_READ;
            end
            rfpa_pkg::ST_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = rfpa_pkg::ST_EVAL;
            end
            rfpa_pkg::ST_EVAL:
            begin
                // wait here until the output register can take the result
                if (out_free)
                begin
                    cmd.eval   = 1'b1;
                    state_next = rfpa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rfpa_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.eval)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rfpa_pkg::ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* rtl/core/rfpa_dpath.sv */
// rfpa_dpath: admission datapath, slot hash and index, replay slot memory,
// verdict, query rate limit, posture accumulator and output register
// depends on rfpa_pkg (item structs, cfg_t, dp_cmd_t, codes)
module rfpa_dpath #(
    parameter int REPLAY_SLOTS = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rfpa_pkg::cfg_t       cfg,
    input  rfpa_pkg::in_item_t   in_item,
    input  rfpa_pkg::dp_cmd_t    cmd,
    output rfpa_pkg::dp_status_t status,
    output rfpa_pkg::out_item_t  out_item
);

    localparam int IDX_W = $clog2(REPLAY_SLOTS);
    localparam int R_W   = IDX_W + 1;
    // floor(2^32 / slots): quotient estimate is low by at most one
    localparam logic [31:0]      RECIP     = 32'(64'h1_0000_0000 / REPLAY_SLOTS);
    localparam logic [31:0]      SLOTS_32  = 32'(REPLAY_SLOTS);
    localparam logic [R_W-1:0]   SLOTS_R   = R_W'(REPLAY_SLOTS);
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(REPLAY_SLOTS - 1);

    typedef struct packed {
        logic [47:0] mac;
        logic [31:0] nonce;
        logic [63:0] stamp;
    } slot_t;

    slot_t              mem [0:REPLAY_SLOTS-1];

    rfpa_pkg::in_item_t item_reg;
    logic [31:0]        q_reg;
    logic [R_W-1:0]     r_reg;
    logic [IDX_W-1:0]   idx_reg;
    slot_t              rd_reg;
    logic [2:0]         pre_verdict_reg;
    logic               qry_ok_reg;
    logic [IDX_W-1:0]   clr_cnt_reg;
    logic [63:0]        last_query_reg;
    logic signed [15:0] accum_reg;
    rfpa_pkg::out_item_t out_reg;

    logic [31:0]        hash;
    logic [63:0]        quot_prod;
    logic [31:0]        qn;
    logic [31:0]        r_full;
    logic [R_W-1:0]     idx_wide;
    logic [IDX_W-1:0]   idx;
    logic [2:0]         pre_verdict;
    logic [63:0]        qdelta;
    logic [63:0]        tdelta;
    logic               live;
    logic               replay;
    logic [2:0]         verdict;
    logic [2:0]         cls;
    logic               accepted;
    logic               qdue;
    logic               pupd;
    logic [3:0]         w_cap;
    logic signed [12:0] prod;
    logic signed [16:0] sum;
    logic signed [16:0] lim;
    logic signed [16:0] nlim;
    logic signed [16:0] clamped;
    logic signed [15:0] acc_after;
    logic signed [16:0] acc17;
    logic signed [16:0] thr;
    logic signed [16:0] nthr;
    logic signed [1:0]  level;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_idx;
    slot_t              wr_data;

    // slot hash and index
    assign hash = item_reg.nonce
                ^ {8'd0, item_reg.src_mac[15:8], 16'd0}
                ^ {16'd0, item_reg.src_mac[7:0], 8'd0};
    assign quot_prod = {32'd0, hash} * {32'd0, RECIP};
    assign qn        = q_reg * SLOTS_32;
    assign r_full    = hash - qn;
    assign idx_wide  = (r_reg >= SLOTS_R) ? (r_reg - SLOTS_R) : r_reg;
    assign idx       = idx_wide[IDX_W-1:0];

    // checks ahead of the replay check
    always_comb
    begin
        if (!item_reg.length_ok)
        begin
            pre_verdict = rfpa_pkg::VERDICT_BAD_LEN;
        end
        else if (item_reg.src_mac == cfg.local_mac)
        begin
            pre_verdict = rfpa_pkg::VERDICT_SELF;
        end
        else if (item_reg.version != cfg.protocol_version)
        begin
            pre_verdict = rfpa_pkg::VERDICT_VERSION;
        end
        else if (!item_reg.check_ok)
        begin
            pre_verdict = rfpa_pkg::VERDICT_CHECK;
        end
        else
        begin
            pre_verdict = rfpa_pkg::VERDICT_OK;
        end
    end

    assign qdelta = item_reg.now_us - last_query_reg;

    // replay test against the slot read out
    assign tdelta = item_reg.now_us - rd_reg.stamp;
    assign live   = (rd_reg.stamp != 64'd0) && (tdelta < {32'd0, cfg.replay_window_us});
    assign replay = (pre_verdict_reg == rfpa_pkg::VERDICT_OK) && live
                  && (rd_reg.nonce == item_reg.nonce) && (rd_reg.mac == item_reg.src_mac);
    assign verdict  = replay ? rfpa_pkg::VERDICT_REPLAY : pre_verdict_reg;
    assign cls      = rfpa_pkg::classify(item_reg.opcode);
    assign accepted = (verdict == rfpa_pkg::VERDICT_OK);
    assign qdue     = accepted && (cls == rfpa_pkg::CLS_QUERY) && qry_ok_reg;
    assign pupd     = accepted && (cls == rfpa_pkg::CLS_POSTURE);

    // posture accumulator
    assign w_cap = ((item_reg.nonce[3:0] & rfpa_pkg::WEIGHT_NIBBLE) > cfg.weight_max)
                 ? cfg.weight_max : (item_reg.nonce[3:0] & rfpa_pkg::WEIGHT_NIBBLE);
    assign prod  = item_reg.cell_state * $signed({1'b0, w_cap});
    assign sum   = {accum_reg[15], accum_reg} + {{4{prod[12]}}, prod};
    assign lim   = {2'b00, cfg.accum_limit};
    assign nlim  = -lim;
    assign clamped = (sum > lim) ? lim : ((sum < nlim) ? nlim : sum);
    assign acc_after = pupd ? clamped[15:0] : accum_reg;
    assign acc17 = {acc_after[15], acc_after};
    assign thr   = {2'b00, cfg.posture_threshold};
    assign nthr  = -thr;
    assign level = (acc17 >= thr) ? rfpa_pkg::LEVEL_HIGH
                 : ((acc17 <= nthr) ? rfpa_pkg::LEVEL_LOW : rfpa_pkg::LEVEL_MID);

    // slot write port: clearing pass or write back of a non-replay
    always_comb
    begin
        if (cmd.clr)
        begin
            wr_en   = 1'b1;
            wr_idx  = clr_cnt_reg;
            wr_data = '0;
        end
        else
        begin
            wr_en         = cmd.eval && (pre_verdict_reg == rfpa_pkg::VERDICT_OK) && !replay;
            wr_idx        = idx_reg;
            wr_data.mac   = item_reg.src_mac;
            wr_data.nonce = item_reg.nonce;
            wr_data.stamp = item_reg.now_us;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        if (cmd.rd)
        begin
            rd_reg  <= mem[idx];
            idx_reg <= idx;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_item;
        end
        if (cmd.quot)
        begin
            q_reg           <= quot_prod[63:32];
            pre_verdict_reg <= pre_verdict;
            qry_ok_reg      <= (qdelta >= {32'd0, cfg.query_interval_us});
        end
        if (cmd.rem)
        begin
            r_reg <= r_full[R_W-1:0];
        end
        if (cmd.eval)
        begin
            out_reg.verdict        <= verdict;
            out_reg.op_class       <= cls;
            out_reg.query_due      <= qdue;
            out_reg.posture_update <= pupd;
            out_reg.posture_level  <= level;
            out_reg.accum_value    <= acc_after;
        end
    end

    // block state cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg    <= '0;
            last_query_reg <= '0;
            accum_reg      <= '0;
        end
        else
        begin
            if (cmd.clr)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.eval)
            begin
                accum_reg <= acc_after;
                if (qdue)
                begin
                    last_query_reg <= item_reg.now_us;
                end
            end
        end
    end

    assign status.clr_last = (clr_cnt_reg == LAST_SLOT);
    assign out_item        = out_reg;

endmodule

/* rtl/core/replay_filtered_packet_admission.sv */
// replay_filtered_packet_admission: top level of the mesh packet admission filter
// instantiates rfpa_cfg, rfpa_ctrl and rfpa_dpath; depends on rfpa_pkg
//
// One header transaction in, one verdict transaction out. A packet is dropped, checked
// in order, for bad length, own source address, version mismatch, failed tag check or
// replay; a replay is the same source address and nonce found live in its direct-mapped
// slot (slot = hash of nonce and the two low address bytes, modulo REPLAY_SLOTS). Every
// packet that reaches the replay check and is not a replay overwrites its slot. Accepted
// posture packets move a saturating accumulator, accepted queries are rate limited.
// After reset the slot memory is swept to zero, one slot per cycle, through all REPLAY_SLOTS
// slots; s_tready stays low during the sweep while apb writes are taken as usual.
// Each transaction then passes these steps from acceptance to a loaded output register:
// accept, reciprocal multiply for the slot quotient, remainder, registered slot read,
// then verdict with write back; the next header is taken in the cycle after. The
// output register lets the next header be accepted while a result still waits on
// m_tready; the block stalls in its last step only if that result is still held.
// Configure only while idle.
module replay_filtered_packet_admission #(
    parameter int REPLAY_SLOTS = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // apb configuration port, register i at byte address 8*i
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rfpa_pkg::ADDR_W-1:0]    paddr,
    input  logic [rfpa_pkg::APB_W-1:0]     pwdata,
    output logic [rfpa_pkg::APB_W-1:0]     prdata,
    output logic                           pready,
    // header input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // src_mac[47:0], length_ok[48], version[56:49], cell_state[64:57],
    // nonce[96:65], check_ok[97], now_us[161:98], zero fill[167:162]
    input  logic [rfpa_pkg::S_TDATA_W-1:0] s_tdata,
    // opcode[7:0]
    input  logic [rfpa_pkg::S_TUSER_W-1:0] s_tuser,
    // verdict output stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // verdict[2:0], query_due[3], posture_update[4], posture_level[6:5],
    // accum_value[22:7], zero fill[23]
    output logic [rfpa_pkg::M_TDATA_W-1:0] m_tdata,
    // op_class[2:0]
    output logic [rfpa_pkg::M_TUSER_W-1:0] m_tuser
);

    rfpa_pkg::cfg_t       cfg;
    rfpa_pkg::in_item_t   in_item;
    rfpa_pkg::out_item_t  out_item;
    rfpa_pkg::dp_cmd_t    cmd;
    rfpa_pkg::dp_status_t status;

    // unpack the header transaction
    always_comb
    begin
        in_item.src_mac    = s_tdata[47:0];
        in_item.length_ok  = s_tdata[48];
        in_item.version    = s_tdata[56:49];
        in_item.cell_state = s_tdata[64:57];
        in_item.nonce      = s_tdata[96:65];
        in_item.check_ok   = s_tdata[97];
        in_item.now_us     = s_tdata[161:98];
        in_item.opcode     = s_tuser;
    end

    // pack the verdict transaction
    assign m_tdata = {1'b0, out_item.accum_value, out_item.posture_level,
                      out_item.posture_update, out_item.query_due, out_item.verdict};
    assign m_tuser = out_item.op_class;

    rfpa_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencing: clear sweep, then accept / quotient / remainder / read / verdict
    rfpa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    rfpa_dpath #(
        .REPLAY_SLOTS (REPLAY_SLOTS)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_item  (in_item),
        .cmd      (cmd),
        .status   (status),
        .out_item (out_item)
    );

endmodule

/* rtl/core/rfpa_checker.sv */
// rfpa_checker: port level assertions for the admission block, bound to the top level
// depends on rfpa_pkg (verdict and class codes)
module rfpa_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           psel,
    input logic                           penable,
    input logic                           pwrite,
    input logic [rfpa_pkg::ADDR_W-1:0]    paddr,
    input logic [rfpa_pkg::APB_W-1:0]     pwdata,
    input logic [rfpa_pkg::APB_W-1:0]     prdata,
    input logic                           pready,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [rfpa_pkg::S_TDATA_W-1:0] s_tdata,
    input logic [rfpa_pkg::S_TUSER_W-1:0] s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [rfpa_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [rfpa_pkg::M_TUSER_W-1:0] m_tuser
);

    // one header in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("header accepted while previous one in flight");

    // held result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_verdict_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[2:0] <= rfpa_pkg::VERDICT_REPLAY)
        else $error("verdict code out of range");

    a_posture_upd: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[4] |->
            m_tdata[2:0] == rfpa_pkg::VERDICT_OK && m_tuser == rfpa_pkg::CLS_POSTURE
            && !m_tdata[3])
        else $error("posture update on a dropped or non-posture packet");

    a_query_due: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[3] |->
            m_tdata[2:0] == rfpa_pkg::VERDICT_OK && m_tuser == rfpa_pkg::CLS_QUERY)
        else $error("query due on a dropped or non-query packet");

endmodule

bind replay_filtered_packet_admission rfpa_checker u_rfpa_checker (.*);
